// ===== hdl/kbp_pkg.sv =====
// ----------------------------------------------------------------------------
// kbp_pkg
// Shared constants and types for the random-bit pool: pool size, generator
// constants, opcodes, register indexes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package kbp_pkg;

  localparam int POOL_WORDS = 16;
  localparam int IDX_W      = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int CFG_IDX_W  = 4;

  localparam logic [31:0] WEYL_INC = 32'd1411392427;
  localparam logic [5:0]  MAX_BITS = 6'd32;

  localparam logic [31:0] SEED0_RST = 32'd123456789;
  localparam logic [31:0] SEED1_RST = 32'd987654321;
  localparam logic [30:0] SEED2_RST = 31'd43219876;
  localparam logic [30:0] SEED3_RST = 31'd6543217;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_DRAW    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEED0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEED1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SEED2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SEED3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic start;
    logic restart;
    logic take;
    logic skip;
    logic refill;
    logic load_out;
  } kbp_cmd_t;

  typedef struct packed {
    logic word_nonzero;
    logic idx_last;
    logic fill_last;
    logic bits_done;
    logic out_free;
  } kbp_status_t;

endpackage

// ===== hdl/kbp_req_if.sv =====
// ----------------------------------------------------------------------------
// kbp_req_if
// Request channel: opcode and bit count with valid/ready.
// ----------------------------------------------------------------------------
interface kbp_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [5:0] num_bits;

  modport source (output valid, output opcode, output num_bits, input ready);
  modport sink   (input valid, input opcode, input num_bits, output ready);
endinterface

// ===== hdl/kbp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kbp_rsp_if
// Result channel: drawn bits with valid/ready.
// ----------------------------------------------------------------------------
interface kbp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_bits;

  modport source (output valid, output random_bits, input ready);
  modport sink   (input valid, input random_bits, output ready);
endinterface

// ===== hdl/kbp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kbp_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface kbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/kbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbp_ctrl
// Controller: sequences restart, pool scan, refill, bit take and result load.
// ----------------------------------------------------------------------------
module kbp_ctrl
  import kbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_opcode,
  output logic        req_ready,
  input  kbp_status_t st,
  output kbp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REFILL,
    S_TAKE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   req_fire;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          cmd.start = 1'b1;
          if (req_opcode == OP_RESTART) begin
            cmd.restart = 1'b1;
            state_next  = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (st.bits_done) begin
          state_next = S_FINISH;
        end else if (st.word_nonzero) begin
          cmd.take = 1'b1;
        end else if (st.idx_last) begin
          state_next = S_REFILL;
        end else begin
          cmd.skip = 1'b1;
        end
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        if (st.fill_last) begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_SCAN;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/kbp_dp.sv =====
// ----------------------------------------------------------------------------
// kbp_dp
// Datapath: seed registers, generator state, bit pool, scan and fill
// counters, bit accumulator and the output register.
// ----------------------------------------------------------------------------
module kbp_dp
  import kbp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  kbp_cmd_t             cmd,
  output kbp_status_t          st,
  input  logic [5:0]           num_bits,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [31:0]          random_bits
);

  logic [31:0] seed0, seed1;
  logic [30:0] seed2, seed3;

  logic [31:0] weyl, xs;
  logic [30:0] older, newer;
  logic        carry;

  logic [31:0] pool [POOL_WORDS];
  logic [IDX_W-1:0] idx, fill;
  logic [5:0]  cnt, target;
  logic [31:0] acc;

  logic [31:0] x1, x2, x3;
  logic [31:0] awc_sum;
  logic [31:0] weyl_next;
  logic [31:0] gen_out;
  logic [31:0] cur_word;

  // one generator step
  always_comb begin
    x1        = xs ^ (xs << 5);
    x2        = x1 ^ (x1 >> 7);
    x3        = x2 ^ (x2 << 22);
    awc_sum   = {1'b0, older} + {1'b0, newer} + {31'b0, carry};
    weyl_next = weyl + WEYL_INC;
    gen_out   = weyl_next + x3 + {1'b0, awc_sum[30:0]};
  end

  assign cur_word = pool[idx];

  assign st.word_nonzero = (cur_word != 32'd0);
  assign st.idx_last     = (idx == IDX_W'(POOL_WORDS - 1));
  assign st.fill_last    = (fill == IDX_W'(POOL_WORDS - 1));
  assign st.bits_done    = (cnt == target);
  assign st.out_free     = !rsp_valid || rsp_ready;

  // seed registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed0 <= SEED0_RST;
      seed1 <= SEED1_RST;
      seed2 <= SEED2_RST;
      seed3 <= SEED3_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEED0: seed0 <= cfg_data;
        REG_SEED1: seed1 <= cfg_data;
        REG_SEED2: seed2 <= cfg_data[30:0];
        REG_SEED3: seed3 <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // generator state and pool
  always_ff @(posedge clk) begin
    if (rst) begin
      weyl  <= SEED0_RST;
      xs    <= SEED1_RST;
      older <= SEED2_RST;
      newer <= SEED3_RST;
      carry <= 1'b0;
      fill  <= '0;
      for (int i = 0; i < POOL_WORDS; i++) begin
        pool[i] <= 32'd0;
      end
    end else if (cmd.restart) begin
      weyl  <= seed0;
      xs    <= seed1;
      older <= seed2;
      newer <= seed3;
      carry <= 1'b0;
      fill  <= '0;
      for (int i = 0; i < POOL_WORDS; i++) begin
        pool[i] <= 32'd0;
      end
    end else if (cmd.refill) begin
      weyl       <= weyl_next;
      xs         <= x3;
      older      <= newer;
      newer      <= awc_sum[30:0];
      carry      <= awc_sum[31];
      pool[fill] <= gen_out;
      fill       <= st.fill_last ? '0 : fill + 1'b1;
    end else if (cmd.take) begin
      pool[idx] <= cur_word >> 1;
    end
  end

  // scan index, bit count and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      cnt    <= '0;
      target <= '0;
      acc    <= '0;
    end else if (cmd.start) begin
      idx    <= '0;
      cnt    <= '0;
      target <= (cmd.restart || num_bits <= MAX_BITS) ?
                (cmd.restart ? 6'd0 : num_bits) : MAX_BITS;
      acc    <= '0;
    end else begin
      if (cmd.skip) begin
        idx <= idx + 1'b1;
      end
      if (cmd.refill && st.fill_last) begin
        idx <= '0;
      end
      if (cmd.take) begin
        acc <= {acc[30:0], cur_word[0]};
        cnt <= cnt + 6'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      random_bits <= acc;
    end
  end

endmodule

// ===== hdl/kiss_random_bit_pool.sv =====
// ----------------------------------------------------------------------------
// kiss_random_bit_pool
// Random-bit source: a KISS-style generator fills a pool of words from which
// requests draw up to 32 bits, first drawn bit most significant.
// ----------------------------------------------------------------------------
// One request at a time. A draw of n bits (n clamped to 32) scans the pool
// one word per cycle from the first word, passing over empty words, and
// takes one bit per cycle; when the scan finds every pool word empty, a
// refill runs one generator step per cycle into one pool word, and a bit is
// then taken from the first word. A restart (opcode 0) returns zero. A result
// still waiting in the output register holds the next result back until it
// is taken. The result sits in an output register, so a finished result may
// wait while the next request is accepted. Seed writes are taken at any time
// and act at the next restart.
module kiss_random_bit_pool
  import kbp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  kbp_req_if.sink  req,
  kbp_rsp_if.source rsp,
  kbp_cfg_if.sink  cfg
);

  kbp_cmd_t    cmd;
  kbp_status_t st;

  assign cfg.ready = 1'b1;

  kbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .st         (st),
    .cmd        (cmd)
  );

  kbp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .num_bits    (req.num_bits),
    .cfg_valid   (cfg.valid && cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .random_bits (rsp.random_bits)
  );

  a_no_take_when_done: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && st.bits_done))
    else $error("bit taken beyond the requested count");

  a_refill_after_empty: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd.refill) |-> $past(st.idx_last && !st.word_nonzero))
    else $error("refill started while the pool still held bits");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("result loaded over an untaken result");

  a_refill_idle_req: assert property (@(posedge clk) disable iff (rst)
    cmd.refill |-> !req.ready)
    else $error("request channel open during refill");

endmodule

// ===== tb/kbp_checker.sv =====
// ----------------------------------------------------------------------------
// kbp_checker
// Watches the request, result and seed-write channels of the random-bit pool.
// Keeps its own copy of the seeds, generator words and pool, works out the
// drawn bits for every accepted request and compares each accepted result
// with the oldest expected value. Hands the mismatch count and the number of
// results still owed to the testbench top.
// ----------------------------------------------------------------------------
module kbp_checker
  import kbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  kbp_req_if   req,
  kbp_rsp_if   rsp,
  kbp_cfg_if   cfg,
  output int   errors,
  output int   outstanding
);

  logic [31:0] seed_w0, seed_w1;
  logic [30:0] seed_w2, seed_w3;
  logic [31:0] weyl_word, xs_word;
  logic [30:0] awc_old, awc_new;
  logic        awc_carry;
  logic [31:0] pool [POOL_WORDS];
  logic [31:0] owed_bits [$];
  logic [31:0] want;

  function automatic void reload_from_seeds();
    weyl_word = seed_w0;
    xs_word   = seed_w1;
    awc_old   = seed_w2;
    awc_new   = seed_w3;
    awc_carry = 1'b0;
    for (int w = 0; w < POOL_WORDS; w++) pool[w] = '0;
  endfunction

  function automatic logic [31:0] draw_bits(input logic [5:0] n);
    logic [31:0] acc, x, t;
    int          idx, cnt;
    acc = '0;
    idx = 0;
    cnt = (n > MAX_BITS) ? int'(MAX_BITS) : int'(n);
    for (int k = 0; k < cnt; k++) begin
      while (idx < POOL_WORDS && pool[idx] == '0) idx++;
      if (idx >= POOL_WORDS) begin
        // one generator step per pool word
        for (int w = 0; w < POOL_WORDS; w++) begin
          x = xs_word;
          x = x ^ (x << 5);
          x = x ^ (x >> 7);
          x = x ^ (x << 22);
          xs_word   = x;
          t         = {1'b0, awc_old} + {1'b0, awc_new} + {31'b0, awc_carry};
          awc_old   = awc_new;
          awc_carry = t[31];
          awc_new   = t[30:0];
          weyl_word = weyl_word + WEYL_INC;
          pool[w]   = weyl_word + xs_word + {1'b0, awc_new};
        end
        idx = 0;
      end
      acc       = {acc[30:0], pool[idx][0]};
      pool[idx] = pool[idx] >> 1;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      seed_w0 = SEED0_RST;
      seed_w1 = SEED1_RST;
      seed_w2 = SEED2_RST;
      seed_w3 = SEED3_RST;
      reload_from_seeds();
      owed_bits.delete();
      errors = 0;
    end else begin
      // seeds act at the next restart
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SEED0: seed_w0 = cfg.data;
          REG_SEED1: seed_w1 = cfg.data;
          REG_SEED2: seed_w2 = cfg.data[30:0];
          REG_SEED3: seed_w3 = cfg.data[30:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (owed_bits.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("checker: unexpected transaction, random_bits %08h", rsp.random_bits);
        end else begin
          want = owed_bits.pop_front();
          if (rsp.random_bits !== want) begin
            errors++;
            if (errors <= 10)
              $display("checker: random_bits expected %08h got %08h", want, rsp.random_bits);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.opcode == OP_RESTART) begin
          reload_from_seeds();
          owed_bits.push_back('0);
        end else begin
          owed_bits.push_back(draw_bits(req.num_bits));
        end
      end
    end
    outstanding = owed_bits.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for kiss_random_bit_pool. Drives requests and seed writes, stalls
// the result channel at random, and leaves checking to kbp_checker. A short
// directed run covers zero, oversized and full draws, restarts and a seed set
// whose first pool word is zero; random phases follow, each with new seeds.
// ----------------------------------------------------------------------------
module tb_top;
  import kbp_pkg::*;

  localparam int GAP_MAX         = 13;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 120;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 220;
  // first generator step lands the weyl word on zero
  localparam logic [31:0] WEYL_CANCEL = -WEYL_INC;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, outstanding;
  int   idle_cycles = 0;
  bit   req_burst   = 1'b0;
  bit   rsp_burst   = 1'b0;

  kbp_req_if req ();
  kbp_rsp_if rsp ();
  kbp_cfg_if cfg ();

  kiss_random_bit_pool uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  kbp_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input logic op, input logic [5:0] n);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.num_bits <= n;
    do @(posedge clk); while (!req.ready);
    if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side
  initial begin
    int stall;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
    end
  end

  initial begin
    logic [31:0] seeds [4];
    int          roll;
    req.valid    <= 1'b0;
    req.opcode   <= OP_DRAW;
    req.num_bits <= '0;
    cfg.valid    <= 1'b0;
    cfg.index    <= REG_SEED0;
    cfg.data     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset seeds: zero, single, full and oversized draws, then pool exhaustion
    send_req(OP_DRAW, '0);
    send_req(OP_DRAW, 6'd1);
    send_req(OP_DRAW, MAX_BITS);
    send_req(OP_DRAW, MAX_BITS + 6'd1);
    send_req(OP_DRAW, '1);
    send_req(OP_DRAW, MAX_BITS - 6'd1);
    send_req(OP_RESTART, '1);
    send_req(OP_DRAW, MAX_BITS);
    repeat (12) send_req(OP_DRAW, MAX_BITS);

    // zero xorshift and add-with-carry seeds, first pool word zero after refill
    wait_drained();
    write_reg(REG_SEED0, WEYL_CANCEL);
    write_reg(REG_SEED1, '0);
    write_reg(REG_SEED2, '0);
    write_reg(REG_SEED3, '0);
    send_req(OP_DRAW, 6'd5);
    send_req(OP_RESTART, '0);
    send_req(OP_DRAW, MAX_BITS);
    send_req(OP_DRAW, MAX_BITS);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        1:       seeds = '{32'd0, 32'd1, 32'd0, 32'd0};
        2:       seeds = '{default: '1};
        default: foreach (seeds[s]) seeds[s] = $urandom();
      endcase
      if (p == 3) seeds[1] = '0;
      write_reg(REG_SEED0, seeds[0]);
      write_reg(REG_SEED1, seeds[1]);
      write_reg(REG_SEED2, seeds[2]);
      write_reg(REG_SEED3, seeds[3]);
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_SEED3) + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom());
      send_req(OP_RESTART, 6'($urandom()));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          send_req(OP_RESTART, 6'($urandom()));
        else if (roll < 10)
          send_req(OP_DRAW, '0);
        else if (roll < 20)
          send_req(OP_DRAW, 6'($urandom_range(int'(MAX_BITS) + 1, 63)));
        else
          send_req(OP_DRAW, 6'($urandom_range(1, int'(MAX_BITS))));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
